// File: design/y86_instruction_fetch_decode_assert.svh
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode assertion macros
// Shared wrappers for the concurrent checks of the decode block.
// ----------------------------------------------------------------------------
`ifndef Y86_INSTRUCTION_FETCH_DECODE_ASSERT_SVH
`define Y86_INSTRUCTION_FETCH_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Y86FD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("y86fd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define Y86FD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("y86fd check failed");

`endif

// File: design/y86fd_pkg.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode package
// Instruction codes, status codes, lengths and the transaction payload types.
// ----------------------------------------------------------------------------
package y86fd_pkg;

	localparam logic [3:0] ICODE_HALT    = 4'd0;
	localparam logic [3:0] ICODE_NOP     = 4'd1;
	localparam logic [3:0] ICODE_CMOV    = 4'd2;
	localparam logic [3:0] ICODE_IRMOVQ  = 4'd3;
	localparam logic [3:0] ICODE_RMMOVQ  = 4'd4;
	localparam logic [3:0] ICODE_MRMOVQ  = 4'd5;
	localparam logic [3:0] ICODE_OPQ     = 4'd6;
	localparam logic [3:0] ICODE_JXX     = 4'd7;
	localparam logic [3:0] ICODE_CALL    = 4'd8;
	localparam logic [3:0] ICODE_RET     = 4'd9;
	localparam logic [3:0] ICODE_PUSHQ   = 4'd10;
	localparam logic [3:0] ICODE_POPQ    = 4'd11;
	localparam logic [3:0] ICODE_IOTRAP  = 4'd12;
	localparam logic [3:0] ICODE_INVALID = 4'd13;

	// Largest legal function code per class.
	localparam logic [3:0] IFUN_MAX_CMOV   = 4'd6;
	localparam logic [3:0] IFUN_MAX_OPQ    = 4'd3;
	localparam logic [3:0] IFUN_MAX_JXX    = 4'd6;
	localparam logic [3:0] IFUN_MAX_IOTRAP = 4'd5;
	localparam logic [3:0] IFUN_PLAIN      = 4'd0;

	localparam logic [3:0] REG_NONE = 4'hF;

	localparam logic [3:0] LEN_BYTE  = 4'd1;
	localparam logic [3:0] LEN_REGS  = 4'd2;
	localparam logic [3:0] LEN_DEST  = 4'd9;
	localparam logic [3:0] LEN_FULL  = 4'd10;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_ADR = 2'd1;
	localparam logic [1:0] STATUS_INS = 2'd2;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  opcode_byte;
		logic [7:0]  second_byte;
		logic [63:0] tail_bytes;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  icode;
		logic [3:0]  ifun;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [63:0] const_value;
		logic [15:0] next_pc;
		logic [1:0]  status;
	} out_item_t;

endpackage

// File: design/y86fd_in_if.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode input channel
// Valid/ready channel carrying the pc and the instruction bytes.
// ----------------------------------------------------------------------------
interface y86fd_in_if import y86fd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/y86fd_out_if.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode output channel
// Valid/ready channel carrying one decoded instruction.
// ----------------------------------------------------------------------------
interface y86fd_out_if import y86fd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/y86fd_decode.sv
// ----------------------------------------------------------------------------
// Y86-64 instruction decode
// Combinational split, class checks, bounds check and constant assembly.
// ----------------------------------------------------------------------------
module y86fd_decode import y86fd_pkg::*; #(
	parameter int MEM_SIZE = 8192
) (
	input  in_item_t  item,
	output out_item_t result
);

	localparam logic [16:0] MemLimit = 17'(MEM_SIZE);

	logic [3:0]  ic;
	logic [3:0]  fn;
	logic [3:0]  ra;
	logic [3:0]  rbn;
	logic [3:0]  len;
	logic [63:0] cval;
	logic [3:0]  oa;
	logic [3:0]  ob;
	logic        fn_ok;
	logic        reg_ok;
	logic        pc_ok;
	logic        end_ok;
	logic [16:0] end_addr;

	assign ic  = item.opcode_byte[7:4];
	assign fn  = item.opcode_byte[3:0];
	assign ra  = item.second_byte[7:4];
	assign rbn = item.second_byte[3:0];

	always_comb begin
		len    = LEN_BYTE;
		cval   = '0;
		oa     = REG_NONE;
		ob     = REG_NONE;
		fn_ok  = 1'b0;
		reg_ok = 1'b1;
		case (ic)
			ICODE_HALT, ICODE_NOP, ICODE_RET: begin
				fn_ok = (fn == IFUN_PLAIN);
			end
			ICODE_IOTRAP: begin
				fn_ok = (fn <= IFUN_MAX_IOTRAP);
			end
			ICODE_CMOV, ICODE_OPQ: begin
				fn_ok  = (ic == ICODE_CMOV) ? (fn <= IFUN_MAX_CMOV) : (fn <= IFUN_MAX_OPQ);
				len    = LEN_REGS;
				reg_ok = (ra != REG_NONE) && (rbn != REG_NONE);
				oa     = ra;
				ob     = rbn;
			end
			ICODE_IRMOVQ: begin
				fn_ok  = (fn == IFUN_PLAIN);
				len    = LEN_FULL;
				reg_ok = (ra == REG_NONE) && (rbn != REG_NONE);
				oa     = ra;
				ob     = rbn;
				cval   = item.tail_bytes;
			end
			ICODE_RMMOVQ, ICODE_MRMOVQ: begin
				fn_ok  = (fn == IFUN_PLAIN);
				len    = LEN_FULL;
				reg_ok = (ra != REG_NONE);
				oa     = ra;
				ob     = rbn;
				cval   = item.tail_bytes;
			end
			ICODE_JXX, ICODE_CALL: begin
				fn_ok = (ic == ICODE_JXX) ? (fn <= IFUN_MAX_JXX) : (fn == IFUN_PLAIN);
				len   = LEN_DEST;
				// The destination starts straight after the opcode byte.
				cval  = {item.tail_bytes[55:0], item.second_byte};
			end
			ICODE_PUSHQ, ICODE_POPQ: begin
				fn_ok  = (fn == IFUN_PLAIN);
				len    = LEN_REGS;
				reg_ok = (ra != REG_NONE) && (rbn == REG_NONE);
				oa     = ra;
				ob     = rbn;
			end
			default: begin
				fn_ok = 1'b0;
			end
		endcase
	end

	assign end_addr = {1'b0, item.pc} + 17'(len);
	assign pc_ok    = ({1'b0, item.pc} < MemLimit);
	assign end_ok   = (end_addr <= MemLimit);

	always_comb begin
		result.icode       = ICODE_INVALID;
		result.ifun        = fn;
		result.reg_a       = REG_NONE;
		result.reg_b       = REG_NONE;
		result.const_value = '0;
		result.next_pc     = item.pc + 16'd1;
		result.status      = STATUS_INS;
		if (!pc_ok) begin
			result.ifun    = '0;
			result.next_pc = item.pc;
			result.status  = STATUS_ADR;
		end else if (!fn_ok) begin
			result.status = STATUS_INS;
		end else if (!end_ok) begin
			// The function check takes precedence over running past memory.
			result.status = STATUS_ADR;
		end else if (!reg_ok) begin
			result.status = STATUS_INS;
		end else begin
			result.icode       = ic;
			result.reg_a       = oa;
			result.reg_b       = ob;
			result.const_value = cval;
			result.next_pc     = end_addr[15:0];
			result.status      = STATUS_OK;
		end
	end

endmodule

// File: design/y86_instruction_fetch_decode.sv
// ----------------------------------------------------------------------------
// Y86-64 instruction fetch decode
// Decodes one instruction per transaction into icode, registers, constant,
// next pc and status.
// ----------------------------------------------------------------------------
// The block accepts one instruction every clock cycle while the output is not
// stalled: the bytes are captured in an input register, decoded in one pass
// of combinational logic and held in a result register until the consumer
// takes them. While the result register is full and stalled, a second
// instruction waits in the input register; a stall on the output side
// reaches the input ready in the same cycle.
module y86_instruction_fetch_decode import y86fd_pkg::*; #(
	parameter int MEM_SIZE = 8192
) (
	input logic        clk,
	input logic        arst_n,
	y86fd_in_if.sink   in_ch,
	y86fd_out_if.source out_ch
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t decoded;
	logic      advance_s2;
	logic      ready_s1;

	assign advance_s2  = !valid_s2 || out_ch.ready;
	assign ready_s1    = !valid_s1 || advance_s2;
	assign in_ch.ready = ready_s1;

	y86fd_decode #(
		.MEM_SIZE(MEM_SIZE)
	) u_decode (
		.item  (item_s1),
		.result(decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && ready_s1) begin
			item_s1 <= in_ch.data;
		end
		if (valid_s1 && advance_s2) begin
			result_s2 <= decoded;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = result_s2;

endmodule

// File: design/y86fd_checker.sv
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode checker
// Port-level checks on the decoded output, bound to the top level.
// ----------------------------------------------------------------------------
`include "y86_instruction_fetch_decode_assert.svh"

module y86fd_checker import y86fd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result must be held unchanged.
	`Y86FD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// Any error hides the decoded fields.
	`Y86FD_ASSERT_NOW(a_err_fields, clk, arst_n, out_valid && (out_data.status != STATUS_OK), (out_data.icode == ICODE_INVALID) && (out_data.reg_a == REG_NONE) && (out_data.reg_b == REG_NONE) && (out_data.const_value == 64'd0))

	// A good decode never reports the invalid code.
	`Y86FD_ASSERT_NOW(a_ok_icode, clk, arst_n, out_valid && (out_data.status == STATUS_OK), out_data.icode != ICODE_INVALID)

	// Instructions without a register byte name no registers.
	`Y86FD_ASSERT_NOW(a_no_regs, clk, arst_n, out_valid && (out_data.status == STATUS_OK) && ((out_data.icode == ICODE_HALT) || (out_data.icode == ICODE_NOP) || (out_data.icode == ICODE_RET) || (out_data.icode == ICODE_IOTRAP) || (out_data.icode == ICODE_JXX) || (out_data.icode == ICODE_CALL)), (out_data.reg_a == REG_NONE) && (out_data.reg_b == REG_NONE))

endmodule

bind y86_instruction_fetch_decode y86fd_checker u_y86fd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Y86-64 fetch/decode testbench
// Drives instructions into the decoder over the valid/ready input channel
// and checks every decoded transaction against its table entry or an in-bench
// decode predictor. A short table covers each class, the extremes and the
// error cases, and constrained-by-hand random instructions follow. Both
// channels idle at random, with one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
module tb_top;
	import y86fd_pkg::*;

	localparam int MEM_SZ     = 8192;
	localparam int RAND_ITEMS = 1600;
	localparam int LONG_HOLD  = 300;

	typedef struct {
		logic [15:0] pc;
		out_item_t   res;
	} decode_due_t;

	typedef struct {
		bit        typed;
		out_item_t res;
	} known_result_t;

	typedef struct {
		in_item_t      ins;
		known_result_t known;
	} dir_row_t;

	logic clk;
	logic arst_n;

	y86fd_in_if  in_bus();
	y86fd_out_if out_bus();

	decode_due_t   pending_decodes[$];
	known_result_t known_q[$];
	dir_row_t      dir_rows[$];

	int unsigned err_cnt = 0;
	int unsigned results_seen = 0;
	int unsigned n_ok = 0;
	int unsigned n_adr = 0;
	int unsigned n_ins = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          long_hold_req = 1'b0;

	y86_instruction_fetch_decode #(.MEM_SIZE(MEM_SZ)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic out_item_t mk_res(input logic [3:0] ic, input logic [3:0] fn,
			input logic [3:0] ra, input logic [3:0] rb, input logic [63:0] cv,
			input logic [15:0] npc, input logic [1:0] st);
		out_item_t r;
		r.icode       = ic;
		r.ifun        = fn;
		r.reg_a       = ra;
		r.reg_b       = rb;
		r.const_value = cv;
		r.next_pc     = npc;
		r.status      = st;
		return r;
	endfunction

	// Decode of one instruction as the block should see it.
	function automatic out_item_t predict_decode(input in_item_t it);
		logic [3:0]  ic;
		logic [3:0]  fn;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  oa;
		logic [3:0]  ob;
		logic [63:0] cv;
		logic [1:0]  st;
		int          len;
		bit          fn_ok;
		bit          reg_ok;
		ic = it.opcode_byte[7:4];
		fn = it.opcode_byte[3:0];
		ra = it.second_byte[7:4];
		rb = it.second_byte[3:0];
		oa = REG_NONE;
		ob = REG_NONE;
		cv = '0;
		len = int'(LEN_BYTE);
		fn_ok = 1'b0;
		reg_ok = 1'b1;
		if (int'(it.pc) >= MEM_SZ)
			return mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, it.pc,
				STATUS_ADR);
		case (ic)
			ICODE_HALT, ICODE_NOP, ICODE_RET: begin
				fn_ok = (fn == IFUN_PLAIN);
			end
			ICODE_IOTRAP: begin
				fn_ok = (fn <= IFUN_MAX_IOTRAP);
			end
			ICODE_CMOV, ICODE_OPQ: begin
				fn_ok = (ic == ICODE_CMOV) ? (fn <= IFUN_MAX_CMOV)
					: (fn <= IFUN_MAX_OPQ);
				len = int'(LEN_REGS);
				reg_ok = (ra != REG_NONE) && (rb != REG_NONE);
				oa = ra;
				ob = rb;
			end
			ICODE_IRMOVQ: begin
				fn_ok = (fn == IFUN_PLAIN);
				len = int'(LEN_FULL);
				reg_ok = (ra == REG_NONE) && (rb != REG_NONE);
				oa = ra;
				ob = rb;
				cv = it.tail_bytes;
			end
			ICODE_RMMOVQ, ICODE_MRMOVQ: begin
				fn_ok = (fn == IFUN_PLAIN);
				len = int'(LEN_FULL);
				reg_ok = (ra != REG_NONE);
				oa = ra;
				ob = rb;
				cv = it.tail_bytes;
			end
			ICODE_JXX, ICODE_CALL: begin
				fn_ok = (ic == ICODE_JXX) ? (fn <= IFUN_MAX_JXX) : (fn == IFUN_PLAIN);
				len = int'(LEN_DEST);
				cv = {it.tail_bytes[55:0], it.second_byte};
			end
			ICODE_PUSHQ, ICODE_POPQ: begin
				fn_ok = (fn == IFUN_PLAIN);
				len = int'(LEN_REGS);
				reg_ok = (ra != REG_NONE) && (rb == REG_NONE);
				oa = ra;
				ob = rb;
			end
			default: begin
				fn_ok = 1'b0;
			end
		endcase
		// The function check takes priority over the length check.
		if (!fn_ok)
			st = STATUS_INS;
		else if (int'(it.pc) + len > MEM_SZ)
			st = STATUS_ADR;
		else if (!reg_ok)
			st = STATUS_INS;
		else
			st = STATUS_OK;
		if (st == STATUS_OK)
			return mk_res(ic, fn, oa, ob, cv, 16'(int'(it.pc) + len), STATUS_OK);
		return mk_res(ICODE_INVALID, fn, REG_NONE, REG_NONE, 64'd0, it.pc + 16'd1, st);
	endfunction

	function automatic in_item_t gen_instr();
		in_item_t    it;
		int unsigned sel;
		logic [3:0]  ic;
		logic [3:0]  fn;
		logic [3:0]  ra;
		logic [3:0]  rb;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			it.pc = 16'($urandom_range(MEM_SZ, 65535));
		else if (sel < 20)
			it.pc = 16'($urandom_range(MEM_SZ - 12, MEM_SZ - 1));
		else
			it.pc = 16'($urandom_range(0, MEM_SZ - 1));
		it.tail_bytes = {$urandom, $urandom};
		it.second_byte = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 20) begin
			it.opcode_byte = 8'($urandom_range(0, 255));
		end else begin
			ic = 4'($urandom_range(ICODE_HALT, ICODE_IOTRAP));
			case (ic)
				ICODE_CMOV:   fn = 4'($urandom_range(0, IFUN_MAX_CMOV));
				ICODE_JXX:    fn = 4'($urandom_range(0, IFUN_MAX_JXX));
				ICODE_OPQ:    fn = 4'($urandom_range(0, IFUN_MAX_OPQ));
				ICODE_IOTRAP: fn = 4'($urandom_range(0, IFUN_MAX_IOTRAP));
				default:      fn = IFUN_PLAIN;
			endcase
			if ($urandom_range(0, 99) < 5)
				fn = 4'($urandom_range(0, 15));
			ra = 4'($urandom_range(0, 14));
			rb = 4'($urandom_range(0, 14));
			case (ic)
				ICODE_IRMOVQ:               ra = REG_NONE;
				ICODE_RMMOVQ, ICODE_MRMOVQ: rb = 4'($urandom_range(0, 15));
				ICODE_PUSHQ, ICODE_POPQ:    rb = REG_NONE;
				default:                    ;
			endcase
			// A tenth of the time the register byte is left as noise.
			if ($urandom_range(0, 99) >= 10)
				it.second_byte = {ra, rb};
			it.opcode_byte = {ic, fn};
		end
		return it;
	endfunction

	task automatic add_row(input logic [15:0] pc, input logic [7:0] op,
			input logic [7:0] sec, input logic [63:0] tail, input bit typed,
			input out_item_t res);
		dir_row_t row;
		row.ins.pc          = pc;
		row.ins.opcode_byte = op;
		row.ins.second_byte = sec;
		row.ins.tail_bytes  = tail;
		row.known.typed     = typed;
		row.known.res       = res;
		dir_rows.push_back(row);
	endtask

	// Offers one instruction and returns at the edge where it is taken.
	task automatic offer_instr(input in_item_t it, input known_result_t known);
		int unsigned gap;
		gap = tx_idle_en ? idle_len() : 0;
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		known_q.push_back(known);
		in_bus.valid <= 1'b1;
		in_bus.data  <= it;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		wait (pending_decodes.size() == 0 && known_q.size() == 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		out_item_t     none;
		known_result_t plain;
		logic [15:0]   m;
		int            guard;
		none = '0;
		plain.typed = 1'b0;
		plain.res = '0;
		m = 16'(MEM_SZ);
		in_bus.valid <= 1'b0;
		in_bus.data  <= '0;

		add_row(16'd0, 8'h00, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_HALT, IFUN_PLAIN, REG_NONE, REG_NONE, 64'd0, 16'd1, STATUS_OK));
		add_row(m - 16'd1, 8'h10, 8'hFF, '1, 1'b1,
			mk_res(ICODE_NOP, IFUN_PLAIN, REG_NONE, REG_NONE, 64'd0, m, STATUS_OK));
		add_row(m, 8'h10, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, m, STATUS_ADR));
		add_row(16'hFFFF, 8'hFF, 8'hFF, '1, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'hFFFF, STATUS_ADR));
		add_row(16'd100, 8'hE0, 8'h12, 64'd5, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'd101, STATUS_INS));
		add_row(16'd200, 8'hFF, 8'h34, 64'd5, 1'b1,
			mk_res(ICODE_INVALID, 4'hF, REG_NONE, REG_NONE, 64'd0, 16'd201, STATUS_INS));
		add_row(16'd300, 8'h01, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd1, REG_NONE, REG_NONE, 64'd0, 16'd301, STATUS_INS));
		add_row(16'd400, 8'h26, 8'h3E, '1, 1'b0, none);
		add_row(16'd410, 8'h27, 8'h3E, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd7, REG_NONE, REG_NONE, 64'd0, 16'd411, STATUS_INS));
		add_row(16'd420, 8'h63, 8'h01, 64'd0, 1'b0, none);
		add_row(16'd430, 8'h60, 8'h2F, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'd431, STATUS_INS));
		add_row(16'd0, 8'h30, 8'hF2, '1, 1'b0, none);
		add_row(m - 16'd10, 8'h30, 8'hFE, 64'h8000_0000_0000_0001, 1'b0, none);
		add_row(m - 16'd9, 8'h30, 8'hF0, '1, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, m - 16'd8, STATUS_ADR));
		// A bad function wins over an instruction that would not fit.
		add_row(m - 16'd1, 8'h31, 8'hF0, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd1, REG_NONE, REG_NONE, 64'd0, m, STATUS_INS));
		add_row(16'd500, 8'h30, 8'h12, 64'd9, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'd501, STATUS_INS));
		add_row(16'd510, 8'h40, 8'hE0, 64'hDEAD_BEEF_0123_4567, 1'b0, none);
		add_row(16'd520, 8'h50, 8'hF3, 64'd7, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'd521, STATUS_INS));
		add_row(16'd530, 8'h76, 8'hAB, 64'h0123_4567_89AB_CDEF, 1'b0, none);
		add_row(16'd540, 8'h77, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd7, REG_NONE, REG_NONE, 64'd0, 16'd541, STATUS_INS));
		add_row(m - 16'd9, 8'h80, 8'hFF, '1, 1'b0, none);
		add_row(m - 16'd8, 8'h80, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, m - 16'd7, STATUS_ADR));
		add_row(16'd600, 8'h90, 8'h00, 64'd0, 1'b0, none);
		add_row(16'd610, 8'hA0, 8'h5F, 64'd0, 1'b0, none);
		add_row(16'd620, 8'hA0, 8'h55, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd0, REG_NONE, REG_NONE, 64'd0, 16'd621, STATUS_INS));
		add_row(16'd630, 8'hB0, 8'hEF, 64'd0, 1'b0, none);
		add_row(16'd640, 8'hC5, 8'h00, 64'd0, 1'b0, none);
		add_row(16'd650, 8'hC6, 8'h00, 64'd0, 1'b1,
			mk_res(ICODE_INVALID, 4'd6, REG_NONE, REG_NONE, 64'd0, 16'd651, STATUS_INS));

		wait (arst_n);
		@(posedge clk);
		foreach (dir_rows[i])
			offer_instr(dir_rows[i].ins, dir_rows[i].known);
		wait_drained();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				tx_idle_en = ($urandom_range(0, 3) != 0);
			// The output side holds off while input transactions keep coming.
			if (n == 400) begin
				tx_idle_en = 1'b0;
				long_hold_req = 1'b1;
			end
			if (n == 800)
				wait_drained();
			offer_instr(gen_instr(), plain);
		end
		in_bus.valid <= 1'b0;

		guard = 0;
		while (pending_decodes.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_decodes.size() != 0)
			report_mismatch($sformatf("%0d decoded results never arrived",
				pending_decodes.size()));

		$display("Covered %0d table instructions and %0d random ones, %0d results compared.",
			dir_rows.size(), RAND_ITEMS, results_seen);
		$display("Status mix: %0d ok, %0d address error, %0d bad instruction.",
			n_ok, n_adr, n_ins);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : sink_side
		int unsigned gap;
		int unsigned phase_left;
		phase_left = 0;
		out_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (phase_left == 0) begin
				rx_idle_en = ($urandom_range(0, 3) != 0);
				phase_left = $urandom_range(50, 300);
			end
			if (long_hold_req) begin
				out_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				gap = rx_idle_en ? idle_len() : 0;
				if (gap > 0) begin
					out_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_bus.ready <= 1'b1;
			@(posedge clk);
			phase_left--;
		end
	end

	// Both channels are sampled at the same edge, input side first.
	always @(posedge clk) begin : scoreboard
		known_result_t kr;
		decode_due_t   due;
		out_item_t     got;
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				if (known_q.size() == 0) begin
					report_mismatch("input transaction taken with nothing offered");
				end else begin
					kr = known_q.pop_front();
					due.pc = in_bus.data.pc;
					due.res = kr.typed ? kr.res : predict_decode(in_bus.data);
					pending_decodes.push_back(due);
				end
			end
			if (out_bus.valid && out_bus.ready) begin
				got = out_bus.data;
				if (pending_decodes.size() == 0) begin
					report_mismatch("result transaction with no instruction pending");
				end else begin
					due = pending_decodes.pop_front();
					results_seen++;
					case (due.res.status)
						STATUS_OK:  n_ok++;
						STATUS_ADR: n_adr++;
						default:    n_ins++;
					endcase
					if (got.icode !== due.res.icode)
						report_mismatch($sformatf("pc %h icode got %h want %h",
							due.pc, got.icode, due.res.icode));
					if (got.ifun !== due.res.ifun)
						report_mismatch($sformatf("pc %h ifun got %h want %h",
							due.pc, got.ifun, due.res.ifun));
					if (got.reg_a !== due.res.reg_a)
						report_mismatch($sformatf("pc %h reg_a got %h want %h",
							due.pc, got.reg_a, due.res.reg_a));
					if (got.reg_b !== due.res.reg_b)
						report_mismatch($sformatf("pc %h reg_b got %h want %h",
							due.pc, got.reg_b, due.res.reg_b));
					if (got.const_value !== due.res.const_value)
						report_mismatch($sformatf("pc %h const_value got %h want %h",
							due.pc, got.const_value, due.res.const_value));
					if (got.next_pc !== due.res.next_pc)
						report_mismatch($sformatf("pc %h next_pc got %h want %h",
							due.pc, got.next_pc, due.res.next_pc));
					if (got.status !== due.res.status)
						report_mismatch($sformatf("pc %h status got %0d want %0d",
							due.pc, got.status, due.res.status));
				end
			end
		end
	end

endmodule

// File: sim.f
+incdir+design
design/y86fd_pkg.sv
design/y86fd_in_if.sv
design/y86fd_out_if.sv
design/y86fd_decode.sv
design/y86_instruction_fetch_decode.sv
design/y86fd_checker.sv
tb/tb_top.sv
